FILE: hw/rtl/bte_pkg.sv
// ----------------------------------------------------------------------------
// BACnet tag encoder package
// Request codes, status codes and the record of one encoded tagged item.
// ----------------------------------------------------------------------------
`default_nettype none

package bte_pkg;

    // Request codes carried in req_type.
    localparam logic [2:0] REQ_HEADER  = 3'd0;
    localparam logic [2:0] REQ_UNSIGNED = 3'd1;
    localparam logic [2:0] REQ_BOOLEAN = 3'd2;
    localparam logic [2:0] REQ_OBJ_ID  = 3'd3;
    localparam logic [2:0] REQ_OPENING = 3'd4;
    localparam logic [2:0] REQ_CLOSING = 3'd5;

    // Result status codes.
    localparam logic [1:0] ST_OK            = 2'd0;
    localparam logic [1:0] ST_OVERRUN       = 2'd1;
    localparam logic [1:0] ST_NOT_ENCODABLE = 2'd2;

    // Length/value/type field codes and marker octets.
    localparam logic [2:0] LVT_EXTENDED = 3'd5;
    localparam logic [2:0] LVT_OPENING  = 3'd6;
    localparam logic [2:0] LVT_CLOSING  = 3'd7;
    localparam logic [7:0] LEN_MARK_16  = 8'd254;
    localparam logic [7:0] LEN_MARK_32  = 8'd255;
    localparam logic [7:0] MAX_SHORT_TAG = 8'd14;

    localparam int MAX_OCTETS = 7;

    typedef logic [7:0] t_octet;

    // One encoded item: up to seven octets, octet count (1..7) and status.
    typedef struct packed {
        t_octet [MAX_OCTETS-1:0] octets;
        logic   [2:0]            count;
        logic   [1:0]            status;
    } t_pkt;

endpackage

`default_nettype wire

FILE: hw/rtl/bacnet_tag_value_encoder.sv
// ----------------------------------------------------------------------------
// BACnet tag and length encoder
// Turns one encode request into the octets of a BACnet tagged item, or into
// a single error item, streamed one octet per cycle unless the output stalls.
// ----------------------------------------------------------------------------
//  channel   | direction | tdata                        | tlast       | tuser
//  s (req)   | in        | request fields, 128 bits     | -           | -
//  m (octet) | out       | out_byte, 8 bits             | last octet  | status
//
//  An item has 1 to 7 octets on the output, and the output serialiser sets the
//  sustained rate. Encoding is done in the accept cycle and
//  stored in a holding register, so a request is taken while the previous item
//  still streams out. Reset (synchronous, active low) empties both registers.
//  A stalled output holds its octet; requests stall once the holding register
//  is full and the current item is not leaving.
// ----------------------------------------------------------------------------
`default_nettype none

module bacnet_tag_value_encoder (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // tdata, lowest bit first: req_type[2:0], tag_number[10:3], is_context[11],
    // value[43:12], length_value[75:44], object_type[85:76],
    // instance_number[107:86], buffer_space[123:108], zero fill[127:124]
    input  wire logic [127:0] i_s_tdata,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // tdata: out_byte[7:0]
    output bte_pkg::t_octet   o_m_tdata,
    output logic              o_m_tlast,
    // tuser: status[1:0]
    output logic [1:0]        o_m_tuser
);
    import bte_pkg::*;

    logic [2:0]  req_type;
    logic [7:0]  tag_number;
    logic        is_context;
    logic [31:0] value;
    logic [31:0] length_value;
    logic [9:0]  object_type;
    logic [21:0] instance_number;
    logic [15:0] buffer_space;

    assign req_type        = i_s_tdata[2:0];
    assign tag_number      = i_s_tdata[10:3];
    assign is_context      = i_s_tdata[11];
    assign value           = i_s_tdata[43:12];
    assign length_value    = i_s_tdata[75:44];
    assign object_type     = i_s_tdata[85:76];
    assign instance_number = i_s_tdata[107:86];
    assign buffer_space    = i_s_tdata[123:108];

    t_pkt        r_cur, r_pend, n_pkt;
    logic        r_cur_valid, r_pend_valid;
    logic [2:0]  r_idx;
    logic        s_fire, m_fire, cur_done, move;

    // ------------------------------------------------------------------
    // Encoder
    // ------------------------------------------------------------------
    always_comb begin
        logic        ext;
        logic [2:0]  nh;
        logic [2:0]  nl;
        logic [2:0]  np;
        logic [31:0] len;
        logic        cls;
        logic [2:0]  lvt;
        logic [31:0] pay;
        logic [31:0] pay_al;
        logic        bit_val;
        logic [1:0]  err;
        logic [33:0] cap_sum;
        logic [2:0]  cap_k;
        logic [3:0]  tot;
        t_octet      h0;
        t_octet      lb [5];
        logic [2:0]  p;
        logic [2:0]  off;
        logic [2:0]  j;

        ext     = tag_number > MAX_SHORT_TAG;
        nh      = ext ? 3'd2 : 3'd1;
        bit_val = value != 32'd0;
        err     = ST_OK;
        len     = 32'd0;
        cls     = is_context;
        pay     = 32'd0;
        np      = 3'd0;

        case (req_type)
            REQ_HEADER: begin
                len = length_value;
            end
            REQ_UNSIGNED: begin
                np  = (value > 32'hFF_FFFF) ? 3'd4 : (value > 32'hFFFF) ? 3'd3 :
                      (value > 32'hFF) ? 3'd2 : 3'd1;
                len = {29'd0, np};
                pay = value;
            end
            REQ_BOOLEAN: begin
                if (is_context) begin
                    len = 32'd1;
                    np  = 3'd1;
                    pay = {31'd0, bit_val};
                end else begin
                    len = {31'd0, bit_val};
                end
            end
            REQ_OBJ_ID: begin
                len = 32'd4;
                np  = 3'd4;
                pay = {object_type, instance_number};
            end
            REQ_OPENING, REQ_CLOSING: begin
                cls = 1'b1;
            end
            default: begin
                err = ST_NOT_ENCODABLE;
            end
        endcase

        // Length field: inline, one length octet, or a marker followed by 2 or 4 octets.
        if (len <= 32'd4) begin
            lvt   = len[2:0];
            nl    = 3'd0;
            cap_k = 3'd0;
        end else if (len <= 32'd253) begin
            lvt   = LVT_EXTENDED;
            nl    = 3'd1;
            cap_k = 3'd1;
        end else if (len <= 32'd65535) begin
            lvt   = LVT_EXTENDED;
            nl    = 3'd3;
            cap_k = 3'd4;
        end else begin
            lvt   = LVT_EXTENDED;
            nl    = 3'd5;
            cap_k = 3'd6;
        end
        if (req_type == REQ_OPENING) begin
            lvt = LVT_OPENING;
        end else if (req_type == REQ_CLOSING) begin
            lvt = LVT_CLOSING;
        end

        cap_sum = {2'b00, len} + {31'd0, nh} + {31'd0, cap_k};
        tot     = {1'b0, nh} + {1'b0, np};

        // Checks in the order the encoding applies them.
        if (err == ST_OK) begin
            if (buffer_space == 16'd0) begin
                err = ST_OVERRUN;
            end else if (ext && buffer_space < 16'd2) begin
                err = ST_OVERRUN;
            end else if (len == 32'hFFFF_FFFF) begin
                err = ST_NOT_ENCODABLE;
            end else if (len > 32'd4 && cap_sum > {18'd0, buffer_space}) begin
                err = ST_OVERRUN;
            end else if (np != 3'd0 && {12'd0, tot} > buffer_space) begin
                err = ST_OVERRUN;
            end
        end

        h0 = {(ext ? 4'hF : tag_number[3:0]), cls, lvt};
        lb[0] = (nl == 3'd1) ? len[7:0] : (nl == 3'd3) ? LEN_MARK_16 : LEN_MARK_32;
        lb[1] = (nl == 3'd3) ? len[15:8] : len[31:24];
        lb[2] = (nl == 3'd3) ? len[7:0]  : len[23:16];
        lb[3] = len[15:8];
        lb[4] = len[7:0];

        // Left-align the payload so its first octet sits in the top byte.
        pay_al = pay << {np == 3'd0 ? 3'd0 : (3'd4 - np), 3'd0};

        for (int i = 0; i < MAX_OCTETS; i++) begin
            p   = 3'(i);
            off = p - nh;
            j   = off - nl;
            if (p == 3'd0) begin
                n_pkt.octets[i] = h0;
            end else if (ext && p == 3'd1) begin
                n_pkt.octets[i] = tag_number;
            end else if (off < nl) begin
                n_pkt.octets[i] = lb[off];
            end else if (j < np) begin
                n_pkt.octets[i] = pay_al[31 - 8*j[1:0] -: 8];
            end else begin
                n_pkt.octets[i] = 8'd0;
            end
        end

        if (err != ST_OK) begin
            n_pkt.octets = '0;
            n_pkt.count  = 3'd1;
        end else begin
            n_pkt.count  = nh + nl + np;
        end
        n_pkt.status = err;
    end

    // ------------------------------------------------------------------
    // Holding register and output serialiser
    // ------------------------------------------------------------------
    assign o_m_tvalid = r_cur_valid;
    assign o_m_tdata  = r_cur.octets[r_idx];
    assign o_m_tlast  = r_idx == (r_cur.count - 3'd1);
    assign o_m_tuser  = r_cur.status;

    assign m_fire     = r_cur_valid && i_m_tready;
    assign cur_done   = m_fire && o_m_tlast;
    assign move       = !r_cur_valid || cur_done;
    assign o_s_tready = !r_pend_valid || move;
    assign s_fire     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_idx        <= 3'd0;
        end else begin
            if (move) begin
                r_cur_valid <= r_pend_valid;
                r_idx       <= 3'd0;
                if (s_fire) begin
                    r_pend_valid <= 1'b1;
                end else begin
                    r_pend_valid <= 1'b0;
                end
            end else begin
                if (m_fire) begin
                    r_idx <= r_idx + 3'd1;
                end
                if (s_fire) begin
                    r_pend_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_cur <= r_pend;
        end
        if (s_fire) begin
            r_pend <= n_pkt;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/bte_chk.sv
// ----------------------------------------------------------------------------
// BACnet tag encoder port checker
// Watches the stream ports of the encoder over time.
// ----------------------------------------------------------------------------
`default_nettype none

module bte_chk (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_tvalid,
    input wire logic         o_s_tready,
    input wire logic         o_m_tvalid,
    input wire logic         i_m_tready,
    input wire logic [7:0]   o_m_tdata,
    input wire logic         o_m_tlast,
    input wire logic [1:0]   o_m_tuser
);
    import bte_pkg::*;

    // A stalled octet must not change.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("output octet changed while stalled");

    // An error item is a single zero octet marked last.
    a_err_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != ST_OK |-> o_m_tlast && o_m_tdata == 8'd0)
        else $error("error item is not a single zero octet");

    // Only the three defined status codes appear.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser == ST_OK || o_m_tuser == ST_OVERRUN
            || o_m_tuser == ST_NOT_ENCODABLE)
        else $error("undefined status code");

    // A request is never refused while the output side is empty.
    a_accept_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && !o_m_tvalid |-> o_s_tready)
        else $error("request refused with an empty output");

    // Reset leaves no item on the output.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind bacnet_tag_value_encoder bte_chk u_bte_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BACnet tag encoder testbench
// Streams directed and random encode requests into the encoder under several
// idle and stall patterns, including one long output hold-off, and checks
// every octet, last flag and status against an internal encoding model.
// ----------------------------------------------------------------------------

module tb;

    import bte_pkg::*;

    // Request codes that the encoder does not know.
    localparam logic [2:0] REQ_RESERVED_6 = 3'd6;
    localparam logic [2:0] REQ_RESERVED_7 = 3'd7;

    localparam int HOLD_CYCLES = 400;

    // Laid out so that the packed struct matches tdata bits [123:0].
    typedef struct packed {
        logic [15:0] space;
        logic [21:0] inst;
        logic [9:0]  otype;
        logic [31:0] lenv;
        logic [31:0] val;
        logic        ctx;
        logic [7:0]  tag;
        logic [2:0]  req;
    } enc_req_t;

    typedef struct {
        t_octet     octet;
        logic       last;
        logic [1:0] status;
    } enc_octet_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic [127:0] i_s_tdata = '0;
    logic         i_m_tready = 1'b0;
    logic         o_s_tready;
    logic         o_m_tvalid;
    t_octet       o_m_tdata;
    logic         o_m_tlast;
    logic [1:0]   o_m_tuser;

    enc_req_t     pending_reqs[$];
    enc_octet_t   expected_octets[$];
    int           mismatches = 0;
    int           snd_idle_pct = 0;
    int           rcv_idle_pct = 0;
    bit           hold_go = 1'b0;
    bit           hold_done = 1'b0;
    int           hold_left = 0;

    bacnet_tag_value_encoder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Works out the octets of one tagged item, or its single error item.
    function automatic void encode_tagged_item(enc_req_t r);
        t_octet            b [8];
        int                n;
        int                pay;
        int                cnt;
        int                k;
        logic [1:0]        err;
        logic              ctx;
        logic              truth;
        logic [31:0]       id;
        longint unsigned   len;
        longint unsigned   space;
        longint unsigned   need;
        enc_octet_t        o;
        n = 0;
        pay = 0;
        len = 0;
        need = 0;
        err = ST_OK;
        ctx = r.ctx;
        space = r.space;
        truth = (r.val != 0);
        id = {r.otype, r.inst};
        cnt = r.val > 32'hFFFFFF ? 4 : r.val > 32'hFFFF ? 3 : r.val > 32'hFF ? 2 : 1;
        case (r.req)
            REQ_HEADER: len = r.lenv;
            REQ_UNSIGNED: begin
                len = cnt;
                pay = cnt;
            end
            REQ_BOOLEAN: begin
                // The application form carries the truth value in the length field.
                if (r.ctx) begin
                    len = 1;
                    pay = 1;
                end
            end
            REQ_OBJ_ID: begin
                len = 4;
                pay = 4;
            end
            REQ_OPENING, REQ_CLOSING: ctx = 1'b1;
            default: err = ST_NOT_ENCODABLE;
        endcase
        if (err == ST_OK) begin
            if (space == 0 || (r.tag > MAX_SHORT_TAG && space < 2)) begin
                err = ST_OVERRUN;
            end else begin
                if (r.tag <= MAX_SHORT_TAG) begin
                    b[0] = {r.tag[3:0], ctx, 3'b000};
                    n = 1;
                end else begin
                    b[0] = {4'hF, ctx, 3'b000};
                    b[1] = r.tag;
                    n = 2;
                end
                if (len <= 4) begin
                    b[0][2:0] = len[2:0];
                end else begin
                    b[0][2:0] = LVT_EXTENDED;
                    if (len <= 253) begin
                        need = n + 1 + len;
                        b[n] = len[7:0];
                        n += 1;
                    end else if (len <= 65535) begin
                        need = n + 4 + len;
                        b[n]   = LEN_MARK_16;
                        b[n+1] = len[15:8];
                        b[n+2] = len[7:0];
                        n += 3;
                    end else if (len <= 32'hFFFFFFFE) begin
                        need = n + 6 + len;
                        b[n]   = LEN_MARK_32;
                        b[n+1] = len[31:24];
                        b[n+2] = len[23:16];
                        b[n+3] = len[15:8];
                        b[n+4] = len[7:0];
                        n += 5;
                    end else begin
                        err = ST_NOT_ENCODABLE;
                    end
                    if (err == ST_OK && need > space) err = ST_OVERRUN;
                end
                if (err == ST_OK && n + pay > space) err = ST_OVERRUN;
            end
        end
        if (err != ST_OK) begin
            o.octet = 8'h00;
            o.last = 1'b1;
            o.status = err;
            expected_octets.push_back(o);
            return;
        end
        case (r.req)
            REQ_UNSIGNED: begin
                for (k = cnt; k > 0; k--) begin
                    b[n] = t_octet'(r.val >> (8 * (k - 1)));
                    n++;
                end
            end
            REQ_BOOLEAN: begin
                if (r.ctx) begin
                    b[n] = {7'b0, truth};
                    n++;
                end else begin
                    b[0][0] = truth;
                end
            end
            REQ_OBJ_ID: begin
                b[n]   = id[31:24];
                b[n+1] = id[23:16];
                b[n+2] = id[15:8];
                b[n+3] = id[7:0];
                n += 4;
            end
            REQ_OPENING: b[0][2:0] = LVT_OPENING;
            REQ_CLOSING: b[0][2:0] = LVT_CLOSING;
            default: ;
        endcase
        for (k = 0; k < n; k++) begin
            o.octet = b[k];
            o.last = (k == n - 1);
            o.status = ST_OK;
            expected_octets.push_back(o);
        end
    endfunction

    function automatic enc_req_t mk_req(logic [2:0] rq, logic [7:0] tg, logic cx,
                                        logic [31:0] v, logic [31:0] lv, logic [9:0] ot,
                                        logic [21:0] ins, logic [15:0] sp);
        enc_req_t r;
        r.req = rq;
        r.tag = tg;
        r.ctx = cx;
        r.val = v;
        r.lenv = lv;
        r.otype = ot;
        r.inst = ins;
        r.space = sp;
        return r;
    endfunction

    // Mostly well-formed requests with room to spare or right at the edge,
    // with a share of starved buffers and unknown request codes.
    task automatic queue_random(int count);
        logic [2:0]      rq;
        logic [7:0]      tg;
        logic [31:0]     v;
        logic [31:0]     lv;
        longint unsigned sp;
        int              sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            if (sel < 3) rq = $urandom_range(1) ? REQ_RESERVED_7 : REQ_RESERVED_6;
            else rq = 3'($urandom_range(REQ_HEADER, REQ_CLOSING));
            case ($urandom_range(3))
                0, 1: tg = 8'($urandom_range(0, MAX_SHORT_TAG));
                2: tg = 8'($urandom_range(MAX_SHORT_TAG + 1, 254));
                default: tg = 8'($urandom_range(0, 254));
            endcase
            v = $urandom >> (8 * $urandom_range(0, 3));
            if ($urandom_range(9) == 0) v = 0;
            sel = $urandom_range(99);
            if (sel < 50) lv = $urandom_range(0, 4);
            else if (sel < 75) lv = $urandom_range(5, 300);
            else if (sel < 90) lv = $urandom_range(301, 65535);
            else if (sel < 97) lv = $urandom;
            else lv = 32'hFFFFFFFF;
            sel = $urandom_range(99);
            if (sel < 10) sp = $urandom_range(0, 3);
            else if (sel < 40) sp = $urandom_range(0, 65535);
            else if (lv <= 65535) sp = lv + $urandom_range(0, 8);
            else sp = 65535;
            if (sp > 65535) sp = 65535;
            pending_reqs.push_back(mk_req(rq, tg, 1'($urandom_range(1)), v, lv,
                                          10'($urandom_range(0, 1023)),
                                          22'($urandom_range(0, 4194303)), 16'(sp)));
        end
    endtask

    task automatic wait_requests_taken;
        while (pending_reqs.size() != 0 || i_s_tvalid) @(negedge i_clk);
    endtask

    // Request driver: predicts on acceptance, then offers the next request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) encode_tagged_item(enc_req_t'(i_s_tdata[123:0]));
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= {4'b0, pending_reqs.pop_front()};
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output ready, with one long hold-off so that the encoder backs up.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_go && !hold_done) begin
            i_m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Octet monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_octets.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected octet %02h last %0d status %0d", $time,
                         o_m_tdata, o_m_tlast, o_m_tuser);
            end else begin
                if (o_m_tdata !== expected_octets[0].octet ||
                    o_m_tlast !== expected_octets[0].last ||
                    o_m_tuser !== expected_octets[0].status) begin
                    mismatches++;
                    $display("%0t: expected %02h/%0d/%0d, got %02h/%0d/%0d", $time,
                             expected_octets[0].octet, expected_octets[0].last,
                             expected_octets[0].status, o_m_tdata, o_m_tlast,
                             o_m_tuser);
                end
                void'(expected_octets.pop_front());
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Length field forms, tag forms and their capacity edges.
        pending_reqs.push_back(mk_req(REQ_HEADER, 8'd0, 1'b0, 0, 0, 0, 0, 16'd1));
        pending_reqs.push_back(mk_req(REQ_HEADER, 8'd14, 1'b1, 0, 4, 0, 0, 16'd1));
        pending_reqs.push_back(mk_req(REQ_HEADER, 8'd15, 1'b0, 0, 5, 0, 0, 16'd100));
        pending_reqs.push_back(mk_req(REQ_HEADER, 8'd254, 1'b1, 0, 253, 0, 0, 16'd256));
        pending_reqs.push_back(mk_req(REQ_HEADER, 8'd3, 1'b0, 0, 253, 0, 0, 16'd254));
        pending_reqs.push_back(mk_req(REQ_HEADER, 8'd7, 1'b1, 0, 254, 0, 0, 16'd65535));
        pending_reqs.push_back(mk_req(REQ_HEADER, 8'd3, 1'b0, 0, 65530, 0, 0, 16'd65535));
        pending_reqs.push_back(mk_req(REQ_HEADER, 8'd3, 1'b0, 0, 65535, 0, 0, 16'd65535));
        pending_reqs.push_back(mk_req(REQ_HEADER, 8'd200, 1'b0, 0, 65536, 0, 0, 16'd65535));
        pending_reqs.push_back(mk_req(REQ_HEADER, 8'd9, 1'b1, 0, 32'hFFFFFFFF, 0, 0,
                                      16'd65535));
        pending_reqs.push_back(mk_req(REQ_HEADER, 8'd2, 1'b0, 0, 1, 0, 0, 16'd0));
        pending_reqs.push_back(mk_req(REQ_HEADER, 8'd15, 1'b0, 0, 1, 0, 0, 16'd1));
        // Unsigned sizes from one octet to four, and a payload that does not fit.
        pending_reqs.push_back(mk_req(REQ_UNSIGNED, 8'd2, 1'b0, 32'h0, 0, 0, 0, 16'd2));
        pending_reqs.push_back(mk_req(REQ_UNSIGNED, 8'd1, 1'b1, 32'h100, 0, 0, 0, 16'd3));
        pending_reqs.push_back(mk_req(REQ_UNSIGNED, 8'd30, 1'b0, 32'h10000, 0, 0, 0, 16'd5));
        pending_reqs.push_back(mk_req(REQ_UNSIGNED, 8'd254, 1'b1, 32'hFFFFFFFF, 0, 0, 0,
                                      16'd6));
        pending_reqs.push_back(mk_req(REQ_UNSIGNED, 8'd4, 1'b0, 32'hFFFFFFFF, 0, 0, 0, 16'd4));
        // Booleans in both classes, with the context form one octet short.
        pending_reqs.push_back(mk_req(REQ_BOOLEAN, 8'd1, 1'b0, 32'h80000000, 0, 0, 0, 16'd1));
        pending_reqs.push_back(mk_req(REQ_BOOLEAN, 8'd1, 1'b0, 32'h0, 0, 0, 0, 16'd1));
        pending_reqs.push_back(mk_req(REQ_BOOLEAN, 8'd20, 1'b1, 32'h1, 0, 0, 0, 16'd3));
        pending_reqs.push_back(mk_req(REQ_BOOLEAN, 8'd5, 1'b1, 32'h1, 0, 0, 0, 16'd1));
        // Object identifiers, opening and closing tags, and unknown requests.
        pending_reqs.push_back(mk_req(REQ_OBJ_ID, 8'd12, 1'b1, 0, 0, 10'd1023, 22'h3FFFFF,
                                      16'd5));
        pending_reqs.push_back(mk_req(REQ_OBJ_ID, 8'd12, 1'b0, 0, 0, 10'd0, 22'd0, 16'd4));
        pending_reqs.push_back(mk_req(REQ_OPENING, 8'd15, 1'b0, 0, 0, 0, 0, 16'd2));
        pending_reqs.push_back(mk_req(REQ_CLOSING, 8'd5, 1'b0, 0, 0, 0, 0, 16'd1));
        pending_reqs.push_back(mk_req(REQ_RESERVED_6, 8'd0, 1'b0, 0, 0, 0, 0, 16'd10));
        pending_reqs.push_back(mk_req(REQ_RESERVED_7, 8'd0, 1'b1, 0, 0, 0, 0, 16'd0));
        wait_requests_taken();

        hold_go = 1'b1;
        queue_random(100);
        wait_requests_taken();

        snd_idle_pct = 58;
        queue_random(100);
        wait_requests_taken();

        snd_idle_pct = 0;
        rcv_idle_pct = 58;
        queue_random(100);
        wait_requests_taken();

        snd_idle_pct = 13;
        rcv_idle_pct = 13;
        queue_random(100);
        wait_requests_taken();

        while (expected_octets.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (expected_octets.size() != 0) begin
            mismatches++;
            $display("%0t: %0d expected octets never arrived", $time, expected_octets.size());
        end
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
